### sv/string_escape_decoder_defines.svh
// Assertion macros shared by the string escape decoder modules.
`ifndef STRING_ESCAPE_DECODER_DEFINES_SVH
`define STRING_ESCAPE_DECODER_DEFINES_SVH

// Check cons in the same cycle as ante; clocked on clk, off during reset.
`define SED_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check cons in the cycle after ante.
`define SED_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/sed_pkg.sv
// Shared types and character constants for the string escape decoder.
package sed_pkg;

	// Raw characters that steer decoding
	localparam logic [7:0] CHR_BSLASH = 8'h5c;
	localparam logic [7:0] CHR_N      = 8'h6e;
	localparam logic [7:0] CHR_R      = 8'h72;
	localparam logic [7:0] CHR_T      = 8'h74;
	localparam logic [7:0] CHR_E      = 8'h65;
	localparam logic [7:0] CHR_ZERO   = 8'h30;
	localparam logic [7:0] CHR_NINE   = 8'h39;
	localparam logic [7:0] CHR_X      = 8'h78;
	localparam logic [7:0] CHR_LC_A   = 8'h61;
	localparam logic [7:0] CHR_LC_F   = 8'h66;

	// Decoded values of the named escapes
	localparam logic [7:0] VAL_NEWLINE = 8'd10;
	localparam logic [7:0] VAL_CR      = 8'd13;
	localparam logic [7:0] VAL_TAB     = 8'd9;
	localparam logic [7:0] VAL_ESC     = 8'd27;
	localparam logic [7:0] VAL_NUL     = 8'd0;

	// Offset of 'a' in hex digit value
	localparam logic [3:0] HEX_ALPHA_OFS = 4'd10;

	// One queue entry: the one or two results that an input item causes
	typedef struct packed {
		logic       two;     // a second result follows the first
		logic       valid0;  // first result carries a decoded byte
		logic [7:0] byte0;
		logic [7:0] byte1;
		logic       last;    // the item ended the literal
	} sed_entry_t;

endpackage

### sv/sed_front.sv
// Front end: accepts raw bytes, tracks escape mode and builds queue entries.
`include "string_escape_decoder_defines.svh"

module sed_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic [7:0]          in_byte,
	input  logic                in_last,
	input  logic                q_full,
	output logic                full,
	output logic                wr_en,
	output sed_pkg::sed_entry_t wr_ent
);

	typedef enum logic [1:0] {
		MODE_NORMAL,
		MODE_ESCAPE,
		MODE_HEX0,
		MODE_HEX1
	} mode_t;

	mode_t      mode_q, mode_d;
	logic [7:0] acc_q, acc_d;
	logic       accept;
	logic       is_num, is_alpha, is_digit;
	logic [3:0] dval;
	logic       have_a, valid_a, have_b;
	logic [7:0] byte_a, byte_b;

	assign full   = q_full;
	assign accept = push && !q_full;

	// Classify the byte as a lower-case hex digit
	always_comb begin
		is_num   = (in_byte >= sed_pkg::CHR_ZERO) && (in_byte <= sed_pkg::CHR_NINE);
		is_alpha = (in_byte >= sed_pkg::CHR_LC_A) && (in_byte <= sed_pkg::CHR_LC_F);
		is_digit = is_num || is_alpha;
		if (is_alpha) begin
			dval = 4'(in_byte - sed_pkg::CHR_LC_A) + sed_pkg::HEX_ALPHA_OFS;
		end else begin
			dval = in_byte[3:0];
		end
	end

	// Work out next mode and the results of this item
	always_comb begin
		mode_d  = mode_q;
		acc_d   = acc_q;
		have_a  = 1'b0;
		valid_a = 1'b1;
		byte_a  = 8'd0;
		have_b  = 1'b0;
		byte_b  = in_byte;
		case (mode_q)
			MODE_NORMAL: begin
				if (in_byte == sed_pkg::CHR_BSLASH) begin
					mode_d = MODE_ESCAPE;
				end else begin
					have_a = 1'b1;
					byte_a = in_byte;
				end
			end
			MODE_ESCAPE: begin
				mode_d = MODE_NORMAL;
				have_a = 1'b1;
				case (in_byte)
					sed_pkg::CHR_N:    byte_a = sed_pkg::VAL_NEWLINE;
					sed_pkg::CHR_R:    byte_a = sed_pkg::VAL_CR;
					sed_pkg::CHR_T:    byte_a = sed_pkg::VAL_TAB;
					sed_pkg::CHR_E:    byte_a = sed_pkg::VAL_ESC;
					sed_pkg::CHR_ZERO: byte_a = sed_pkg::VAL_NUL;
					sed_pkg::CHR_X: begin
						have_a = 1'b0;
						mode_d = MODE_HEX0;
						acc_d  = 8'd0;
					end
					default: byte_a = in_byte;
				endcase
			end
			MODE_HEX0, MODE_HEX1: begin
				if (is_digit && mode_q == MODE_HEX0) begin
					acc_d  = {4'd0, dval};
					mode_d = MODE_HEX1;
				end else if (is_digit) begin
					mode_d = MODE_NORMAL;
					have_a = 1'b1;
					byte_a = {acc_q[3:0], dval};
				end else begin
					// close the escape, then decode the byte as plain input
					mode_d = MODE_NORMAL;
					have_a = 1'b1;
					byte_a = acc_q;
					if (in_byte == sed_pkg::CHR_BSLASH) begin
						mode_d = MODE_ESCAPE;
					end else begin
						have_b = 1'b1;
					end
				end
			end
			default: begin
				mode_d = MODE_NORMAL;
			end
		endcase
		// Flush an open hex escape at the end, else force a marker result if there is none
		if (in_last) begin
			if (mode_d == MODE_HEX0 || mode_d == MODE_HEX1) begin
				have_a = 1'b1;
				byte_a = acc_d;
			end else if (!have_a) begin
				have_a  = 1'b1;
				valid_a = 1'b0;
				byte_a  = 8'd0;
			end
			mode_d = MODE_NORMAL;
			acc_d  = 8'd0;
		end
	end

	assign wr_en         = accept && have_a;
	assign wr_ent.two    = have_b;
	assign wr_ent.valid0 = valid_a;
	assign wr_ent.byte0  = byte_a;
	assign wr_ent.byte1  = byte_b;
	assign wr_ent.last   = in_last;

	// Hold mode and hex value; advance on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
			acc_q  <= 8'd0;
		end else if (accept) begin
			mode_q <= mode_d;
			acc_q  <= acc_d;
		end
	end

	`SED_ASSERT_IMPL(a_hex1_nibble, mode_q == MODE_HEX1, acc_q[7:4] == 4'd0, "hex value overflow after one digit")
	`SED_ASSERT_NEXT(a_last_resets, accept && in_last, mode_q == MODE_NORMAL && acc_q == 8'd0, "mode not cleared after last item")

endmodule

### sv/sed_fifo.sv
// Short queue of decoded entries between front and back end.
`include "string_escape_decoder_defines.svh"

module sed_fifo #(
	parameter int DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  sed_pkg::sed_entry_t wr_ent,
	input  logic                rd_en,
	output sed_pkg::sed_entry_t rd_ent,
	output logic                full,
	output logic                empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	sed_pkg::sed_entry_t mem_q [DEPTH];
	logic [PTR_W-1:0]    wptr_q, rptr_q;
	logic [CNT_W-1:0]    cnt_q;

	assign full   = (cnt_q == CNT_W'(DEPTH));
	assign empty  = (cnt_q == '0);
	assign rd_ent = mem_q[rptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wptr_q] <= wr_ent;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr_en) begin
				wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (rd_en) begin
				rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`SED_ASSERT_IMPL(a_no_overflow, wr_en, !full, "write into full queue")
	`SED_ASSERT_IMPL(a_no_underflow, rd_en, !empty, "read from empty queue")

endmodule

### sv/sed_back.sv
// Back end: takes entries from the queue and hands out one result per pop.
`include "string_escape_decoder_defines.svh"

module sed_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	input  sed_pkg::sed_entry_t rd_ent,
	output logic                rd_en,
	input  logic                pop,
	output logic                empty,
	output logic                out_valid,
	output logic [7:0]          out_byte,
	output logic                out_string_end,
	output logic                out_item_last
);

	sed_pkg::sed_entry_t ent_q;
	logic                have_q;
	logic                phase_q;
	logic                adv, more, free;

	assign adv   = have_q && pop;
	assign more  = !phase_q && ent_q.two;
	assign free  = !have_q || (adv && !more);
	assign rd_en = free && !q_empty;

	// Drive the current result from the held entry
	assign empty          = !have_q;
	assign out_valid      = phase_q ? 1'b1 : ent_q.valid0;
	assign out_byte       = phase_q ? ent_q.byte1 : ent_q.byte0;
	assign out_item_last  = phase_q || !ent_q.two;
	assign out_string_end = ent_q.last && out_item_last;

	// Hold the entry payload
	always_ff @(posedge clk) begin
		if (rd_en) begin
			ent_q <= rd_ent;
		end
	end

	// Step through the results of the held entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q  <= 1'b0;
			phase_q <= 1'b0;
		end else if (adv && more) begin
			phase_q <= 1'b1;
		end else if (free) begin
			have_q  <= !q_empty;
			phase_q <= 1'b0;
		end
	end

	`SED_ASSERT_IMPL(a_phase_two, phase_q, have_q && ent_q.two, "second result without two-result entry")
	`SED_ASSERT_NEXT(a_second_follows, adv && more, !empty && phase_q, "second result lost")

endmodule

### sv/string_escape_decoder.sv
// Top level of the string escape decoder: front end, entry queue, back end.
//
//  channel  | handshake         | payload
//  ---------+-------------------+------------------------------------------------
//  input    | push / full       | in_byte, in_last
//  result   | empty / pop       | out_valid, out_byte, out_string_end, out_item_last
//
// One input byte can be taken every cycle while full is low; mode updates on each accepted byte.
// Results leave at one per cycle while pop is held, from the back end's held entry;
// an item with two results takes two pops, which the DEPTH-entry queue absorbs.
// A result reaches the ports when the back end loads its queue entry.
// arst_n clears mode, queue pointers and the held-entry flag; no clearing pass.
// full rises only when the queue holds DEPTH entries; a stalled pop holds the result.
module string_escape_decoder #(
	parameter int DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       empty,
	input  logic       pop,
	output logic       out_valid,
	output logic [7:0] out_byte,
	output logic       out_string_end,
	output logic       out_item_last
);

	sed_pkg::sed_entry_t wr_ent, rd_ent;
	logic                wr_en, rd_en, q_full, q_empty;

	sed_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.in_byte (in_byte),
		.in_last (in_last),
		.q_full  (q_full),
		.full    (full),
		.wr_en   (wr_en),
		.wr_ent  (wr_ent)
	);

	sed_fifo #(
		.DEPTH (DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (wr_en),
		.wr_ent (wr_ent),
		.rd_en  (rd_en),
		.rd_ent (rd_ent),
		.full   (q_full),
		.empty  (q_empty)
	);

	sed_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_empty        (q_empty),
		.rd_ent         (rd_ent),
		.rd_en          (rd_en),
		.pop            (pop),
		.empty          (empty),
		.out_valid      (out_valid),
		.out_byte       (out_byte),
		.out_string_end (out_string_end),
		.out_item_last  (out_item_last)
	);

endmodule
